@@ sv/nv3_pkg.sv @@
// Package with shared constants and types for the 3D vector normalizer.
`timescale 1ns / 1ps
`default_nettype none
package nv3_pkg;
   localparam int CompWidth  = 16;
   localparam int MagWidth   = CompWidth;
   localparam int FracBits   = 14;
   localparam int QWidth     = FracBits + 1;
   localparam int SumWidth   = 2 * MagWidth + 2;
   localparam int RhsWidth   = 2 * MagWidth + 2 * FracBits + 2;
   localparam int OddWidth   = QWidth + 1;
   localparam int LhsWidth   = 2 * OddWidth + SumWidth;
   localparam int NumLanes   = 3;
   localparam int OutWidth   = 16;

   typedef logic [MagWidth-1:0] mag_type;
   typedef logic [SumWidth-1:0] sum_type;
   typedef logic [RhsWidth-1:0] rhs_type;
   typedef logic [QWidth-1:0]   q_type;

   // Work carried from one cell to the next for one vector.
   typedef struct packed {
      logic                   valid;
      logic                   zero;
      sum_type                sum;
      logic [NumLanes-1:0]    neg;
      rhs_type [NumLanes-1:0] rhs;
      q_type   [NumLanes-1:0] q;
   } cell_data_type;
endpackage
`default_nettype wire

@@ sv/nv3_if.sv @@
// Valid/ready channel interface used for the request and response sides.
`timescale 1ns / 1ps
`default_nettype none
interface nv3_req_if;
   logic                  valid;
   logic                  ready;
   logic signed [15:0]    vec_x;
   logic signed [15:0]    vec_y;
   logic signed [15:0]    vec_z;
   modport source (output valid, vec_x, vec_y, vec_z, input ready);
   modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface nv3_rsp_if;
   logic                  valid;
   logic                  ready;
   logic signed [15:0]    unit_x;
   logic signed [15:0]    unit_y;
   logic signed [15:0]    unit_z;
   logic                  was_zero;
   modport source (output valid, unit_x, unit_y, unit_z, was_zero, input ready);
   modport sink   (input valid, unit_x, unit_y, unit_z, was_zero, output ready);
endinterface
`default_nettype wire

@@ sv/nv3_front.sv @@
// Front stage: magnitudes, sum of squares and scaled squared magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module nv3_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic [nv3_pkg::CompWidth-1:0] in_x,
   input  wire logic [nv3_pkg::CompWidth-1:0] in_y,
   input  wire logic [nv3_pkg::CompWidth-1:0] in_z,
   output nv3_pkg::cell_data_type       out_data
);
   // Stage 1 registers signs and squares; stage 2 forms the sum.
   logic                                      s1_valid_ff, s1_valid_in;
   logic [nv3_pkg::NumLanes-1:0]              s1_neg_ff, s1_neg_in;
   logic [nv3_pkg::NumLanes-1:0][2*nv3_pkg::MagWidth-1:0] s1_sq_ff, s1_sq_in;
   nv3_pkg::cell_data_type                    s2_ff, s2_in;
   logic [nv3_pkg::NumLanes-1:0][nv3_pkg::CompWidth-1:0] comp;
   nv3_pkg::mag_type                          mag;

   assign comp[0] = in_x;
   assign comp[1] = in_y;
   assign comp[2] = in_z;

   always_comb begin
      s1_valid_in = in_valid;
      for (int i = 0; i < nv3_pkg::NumLanes; i++) begin
         s1_neg_in[i] = comp[i][nv3_pkg::CompWidth-1];
         mag = s1_neg_in[i] ? (~comp[i] + 1'b1) : comp[i];
         s1_sq_in[i] = mag * mag;
      end
   end

   always_comb begin
      s2_in = '0;
      s2_in.valid = s1_valid_ff;
      s2_in.neg = s1_neg_ff;
      s2_in.sum = nv3_pkg::SumWidth'(s1_sq_ff[0]) + nv3_pkg::SumWidth'(s1_sq_ff[1])
                + nv3_pkg::SumWidth'(s1_sq_ff[2]);
      s2_in.zero = (s2_in.sum == '0);
      for (int i = 0; i < nv3_pkg::NumLanes; i++) begin
         s2_in.rhs[i] = nv3_pkg::RhsWidth'(s1_sq_ff[i]) << (2 * nv3_pkg::FracBits + 2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_ff.valid <= s2_in.valid;
      end
      if (advance) begin
         s1_neg_ff <= s1_neg_in;
         s1_sq_ff  <= s1_sq_in;
         s2_ff.zero <= s2_in.zero;
         s2_ff.sum <= s2_in.sum;
         s2_ff.neg <= s2_in.neg;
         s2_ff.rhs <= s2_in.rhs;
         s2_ff.q   <= s2_in.q;
      end
   end

   assign out_data = s2_ff;
endmodule
`default_nettype wire

@@ sv/nv3_cell.sv @@
// One cell of the chain: decides one result bit per lane, with two register stages.
`timescale 1ns / 1ps
`default_nettype none
module nv3_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [nv3_pkg::QWidth-1:0] bit_mask,
   input  nv3_pkg::cell_data_type      in_data,
   output nv3_pkg::cell_data_type      out_data
);
   // Trial q = q | bit; accept when (2q-1)^2 * sum <= rhs. Stage a squares
   // the odd value, stage b multiplies by the sum and compares.
   nv3_pkg::cell_data_type             a_ff, a_in, b_in, b_ff;
   logic [nv3_pkg::NumLanes-1:0][2*nv3_pkg::OddWidth-1:0] sq_ff, sq_in;
   logic [nv3_pkg::NumLanes-1:0][nv3_pkg::QWidth-1:0]     trial_ff, trial_in;
   logic [nv3_pkg::OddWidth-1:0]       odd;
   logic [nv3_pkg::LhsWidth-1:0]       lhs;

   always_comb begin
      a_in = in_data;
      for (int i = 0; i < nv3_pkg::NumLanes; i++) begin
         trial_in[i] = in_data.q[i] | bit_mask;
         odd = {trial_in[i], 1'b0} - 1'b1;
         sq_in[i] = odd * odd;
      end
   end

   always_comb begin
      b_in = a_ff;
      for (int i = 0; i < nv3_pkg::NumLanes; i++) begin
         lhs = nv3_pkg::LhsWidth'(sq_ff[i]) * nv3_pkg::LhsWidth'(a_ff.sum);
         if (lhs <= nv3_pkg::LhsWidth'(a_ff.rhs[i])) begin
            b_in.q[i] = trial_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff.valid <= a_in.valid;
         b_ff.valid <= b_in.valid;
      end
      if (advance) begin
         a_ff.zero <= a_in.zero;
         a_ff.sum  <= a_in.sum;
         a_ff.neg  <= a_in.neg;
         a_ff.rhs  <= a_in.rhs;
         a_ff.q    <= a_in.q;
         sq_ff     <= sq_in;
         trial_ff  <= trial_in;
         b_ff.zero <= b_in.zero;
         b_ff.sum  <= b_in.sum;
         b_ff.neg  <= b_in.neg;
         b_ff.rhs  <= b_in.rhs;
         b_ff.q    <= b_in.q;
      end
   end

   assign out_data = b_ff;
endmodule
`default_nettype wire

@@ sv/normalize_vector3.sv @@
// Throughput: one request per cycle when not stalled; a chain of 15 bit cells, one
// per result bit, each with a squaring stage and a multiply-compare stage.
// The whole pipeline holds when the response register is full and not taken.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module normalize_vector3 (
   input wire logic clock,
   input wire logic reset,
   nv3_req_if.sink   req,
   nv3_rsp_if.source rsp
);
   localparam int NumCells = nv3_pkg::QWidth;

   nv3_pkg::cell_data_type chain [NumCells+1];
   logic                   advance;
   logic                   rsp_valid_ff;
   logic signed [15:0]     rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                   rsp_zero_ff;
   logic [nv3_pkg::NumLanes-1:0][nv3_pkg::OutWidth-1:0] packed_q;
   nv3_pkg::cell_data_type last;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   nv3_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req.valid),
      .in_x     (req.vec_x),
      .in_y     (req.vec_y),
      .in_z     (req.vec_z),
      .out_data (chain[0])
   );

   // Cells resolve result bits from most to least significant.
   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      nv3_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .bit_mask (nv3_pkg::QWidth'(1) << (NumCells - 1 - g)),
         .in_data  (chain[g]),
         .out_data (chain[g+1])
      );
   end

   assign last = chain[NumCells];

   always_comb begin
      for (int i = 0; i < nv3_pkg::NumLanes; i++) begin
         packed_q[i] = last.neg[i] ? (~nv3_pkg::OutWidth'(last.q[i]) + 1'b1)
                                   : nv3_pkg::OutWidth'(last.q[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
      end
      if (advance) begin
         rsp_x_ff    <= last.zero ? '0 : packed_q[0];
         rsp_y_ff    <= last.zero ? '0 : packed_q[1];
         rsp_z_ff    <= last.zero ? '0 : packed_q[2];
         rsp_zero_ff <= last.zero;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.unit_x   = rsp_x_ff;
   assign rsp.unit_y   = rsp_y_ff;
   assign rsp.unit_z   = rsp_z_ff;
   assign rsp.was_zero = rsp_zero_ff;
endmodule
`default_nettype wire

@@ sv/nv3_checker.sv @@
// Port-level checker for the normalizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nv3_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        req_ready,
   input wire logic [15:0] unit_x,
   input wire logic [15:0] unit_y,
   input wire logic [15:0] unit_z,
   input wire logic        was_zero
);
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && was_zero |-> unit_x == 16'd0 && unit_y == 16'd0 && unit_z == 16'd0)
      else $error("zero flag with nonzero components");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(unit_x) && $stable(was_zero))
      else $error("stalled response changed");
endmodule

bind normalize_vector3 nv3_checker u_nv3_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .req_ready (req.ready),
   .unit_x    (rsp.unit_x),
   .unit_y    (rsp.unit_y),
   .unit_z    (rsp.unit_z),
   .was_zero  (rsp.was_zero)
);
`default_nettype wire
